// ----- hw/rtl/positional_list_engine_core_macros.svh -----
// Assertion macros for the positional list engine checker.
// Used by the checker file only; no other dependencies.
`ifndef POSITIONAL_LIST_ENGINE_CORE_MACROS_SVH
`define POSITIONAL_LIST_ENGINE_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PLE_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PLE_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/ple_pkg.sv -----
// Shared types and constants for the positional list engine.
// No dependencies; used by every module of the block.
`default_nettype none

package ple_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int CAPACITY_MAX = 64;
    localparam int IDX_W        = $clog2(CAPACITY_MAX);
    localparam int OPC_W        = 3;
    localparam int POS_W        = 7;
    localparam int DATA_W       = 32;
    localparam int KIND_W       = 2;

    typedef enum logic [OPC_W-1:0] {
        OP_INIT   = 3'd0,
        OP_ADD    = 3'd1,
        OP_DELETE = 3'd2,
        OP_LENGTH = 3'd3,
        OP_PRINT  = 3'd4
    } opcode_t;

    localparam logic [KIND_W-1:0] KIND_ELEM  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_LEN   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_EMPTY = 2'd2;

    typedef enum logic {
        ST_IDLE,
        ST_PRINT
    } state_t;

    typedef enum logic [1:0] {
        CM_HOLD,
        CM_ADD,
        CM_DEL,
        CM_ROT
    } cell_mode_t;

    typedef struct packed {
        cell_mode_t       mode;
        logic [IDX_W-1:0] idx;
        logic [IDX_W-1:0] last_idx;
    } cell_ctl_t;

endpackage

`default_nettype wire

// ----- hw/rtl/positional_list_engine_core.sv -----
// Positional list engine top level: sequencer plus a chain of entry cells.
// Depends on ple_pkg, ple_ctrl and ple_cell.
//
// Usage: commands arrive on the input channel (in_valid, in_ready, opcode,
// position, value) and results leave on the output channel (out_valid,
// out_ready, kind, data, last). Each word on either side moves when valid
// and ready are both high.
// Clear, add and delete update the chain in the cycle they are accepted: every cell
// shifts at once from its neighbour, so the next command may be accepted in the following cycle.
// Length gives its single result word in the cycle after acceptance, and so
// does print of an empty list.
// Print of a non-empty list rotates the chain one place per output word: the
// first word is loaded once the sequencer has entered its print state, and the
// input stays blocked until the last word is loaded; after the walk the list is
// back in order.
// Input is accepted only while no print walk runs and the output register
// is free or being emptied in the same cycle.
// When the receiver stalls, the output register holds its word and the walk
// pauses with it. Reset empties the list and drops any pending result; the
// entry cells themselves are not reset.
`default_nettype none

module positional_list_engine_core #(
    parameter int CAPACITY = ple_pkg::CAPACITY_DEF
) (
    input  wire                                    clk,
    input  wire                                    rst_n,
    input  wire                                    in_valid,
    output logic                                   in_ready,
    input  wire logic [ple_pkg::OPC_W-1:0]         opcode,
    input  wire logic [ple_pkg::POS_W-1:0]         position,
    input  wire logic signed [ple_pkg::DATA_W-1:0] value,
    output logic                                   out_valid,
    input  wire                                    out_ready,
    output logic [ple_pkg::KIND_W-1:0]             kind,
    output logic signed [ple_pkg::DATA_W-1:0]      data,
    output logic                                   last
);

    ple_pkg::cell_ctl_t                cell_ctl;
    logic signed [ple_pkg::DATA_W-1:0] cell_data [CAPACITY];

    ple_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .opcode    (opcode),
        .position  (position),
        .head_data (cell_data[0]),
        .cell_ctl  (cell_ctl),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .kind      (kind),
        .data      (data),
        .last      (last)
    );

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic signed [ple_pkg::DATA_W-1:0] left_d;
        logic signed [ple_pkg::DATA_W-1:0] right_d;

        if (i == 0)
        begin : g_first
            assign left_d = '0;
        end
        else
        begin : g_mid_l
            assign left_d = cell_data[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_end
            assign right_d = cell_data[i];
        end
        else
        begin : g_mid_r
            assign right_d = cell_data[i+1];
        end

        ple_cell #(
            .IDX (i)
        ) u_cell (
            .clk        (clk),
            .ctl        (cell_ctl),
            .left_data  (left_d),
            .right_data (right_d),
            .new_data   (value),
            .wrap_data  (cell_data[0]),
            .data_out   (cell_data[i])
        );
    end

endmodule

`default_nettype wire

// ----- hw/rtl/ple_cell.sv -----
// One storage cell of the list chain: holds a single entry.
// Depends on ple_pkg for the broadcast control word.
`default_nettype none

module ple_cell #(
    parameter int IDX = 0
) (
    input  wire                                    clk,
    input  wire ple_pkg::cell_ctl_t                ctl,
    input  wire logic signed [ple_pkg::DATA_W-1:0] left_data,
    input  wire logic signed [ple_pkg::DATA_W-1:0] right_data,
    input  wire logic signed [ple_pkg::DATA_W-1:0] new_data,
    input  wire logic signed [ple_pkg::DATA_W-1:0] wrap_data,
    output logic signed [ple_pkg::DATA_W-1:0]      data_out
);

    localparam logic [ple_pkg::IDX_W-1:0] MY_IDX = ple_pkg::IDX_W'(IDX);

    logic signed [ple_pkg::DATA_W-1:0] entry_reg;
    logic signed [ple_pkg::DATA_W-1:0] entry_next;

    always_comb
    begin
        entry_next = entry_reg;
        case (ctl.mode)
            ple_pkg::CM_ADD:
            begin
                if (MY_IDX > ctl.idx)
                begin
                    entry_next = left_data;
                end
                else if (MY_IDX == ctl.idx)
                begin
                    entry_next = new_data;
                end
            end
            ple_pkg::CM_DEL:
            begin
                if (MY_IDX >= ctl.idx)
                begin
                    entry_next = right_data;
                end
            end
            ple_pkg::CM_ROT:
            begin
                if (MY_IDX == ctl.last_idx)
                begin
                    entry_next = wrap_data;
                end
                else if (MY_IDX < ctl.last_idx)
                begin
                    entry_next = right_data;
                end
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign data_out = entry_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/ple_ctrl.sv -----
// Command sequencer of the list engine: count, print walk and output register.
// Depends on ple_pkg; drives the control word shared by all cells.
`default_nettype none

module ple_ctrl #(
    parameter int CAPACITY = ple_pkg::CAPACITY_DEF
) (
    input  wire                                    clk,
    input  wire                                    rst_n,
    input  wire                                    in_valid,
    output logic                                   in_ready,
    input  wire logic [ple_pkg::OPC_W-1:0]         opcode,
    input  wire logic [ple_pkg::POS_W-1:0]         position,
    input  wire logic signed [ple_pkg::DATA_W-1:0] head_data,
    output ple_pkg::cell_ctl_t                     cell_ctl,
    output logic                                   out_valid,
    input  wire                                    out_ready,
    output logic [ple_pkg::KIND_W-1:0]             kind,
    output logic signed [ple_pkg::DATA_W-1:0]      data,
    output logic                                   last
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = ple_pkg::POS_W + 1;

    ple_pkg::state_t state_reg;
    ple_pkg::state_t state_next;
    ple_pkg::opcode_t op;

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [CNT_W-1:0] prn_reg;
    logic [CNT_W-1:0] prn_next;

    logic                              out_valid_reg;
    logic                              out_valid_next;
    logic [ple_pkg::KIND_W-1:0]        kind_reg;
    logic [ple_pkg::KIND_W-1:0]        kind_next;
    logic signed [ple_pkg::DATA_W-1:0] data_reg;
    logic signed [ple_pkg::DATA_W-1:0] data_next;
    logic                              last_reg;
    logic                              last_next;

    logic             out_free;
    logic             accept;
    logic             prn_last;
    logic [CMP_W-1:0] pos_ext;
    logic [CMP_W-1:0] cnt_ext;
    logic [CMP_W-1:0] pos_m1;
    logic [CMP_W-1:0] add_idx;

    assign op       = ple_pkg::opcode_t'(opcode);
    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == ple_pkg::ST_IDLE) && out_free;
    assign accept   = in_valid && in_ready;
    assign pos_ext  = CMP_W'(position);
    assign cnt_ext  = CMP_W'(count_reg);
    assign pos_m1   = pos_ext - CMP_W'(1);
    assign prn_last = (prn_reg + CNT_W'(1)) == count_reg;

    always_comb
    begin
        if (pos_ext <= CMP_W'(1))
        begin
            add_idx = '0;
        end
        else if (pos_m1 > cnt_ext)
        begin
            add_idx = cnt_ext;
        end
        else
        begin
            add_idx = pos_m1;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ple_pkg::ST_IDLE:
            begin
                if (accept && op == ple_pkg::OP_PRINT && count_reg != '0)
                begin
                    state_next = ple_pkg::ST_PRINT;
                end
            end
            ple_pkg::ST_PRINT:
            begin
                if (out_free && prn_last)
                begin
                    state_next = ple_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ple_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cell_ctl.mode     = ple_pkg::CM_HOLD;
        cell_ctl.idx      = ple_pkg::IDX_W'(add_idx);
        cell_ctl.last_idx = ple_pkg::IDX_W'(cnt_ext - CMP_W'(1));
        count_next        = count_reg;
        prn_next          = prn_reg;
        out_valid_next    = out_valid_reg && !out_ready;
        kind_next         = kind_reg;
        data_next         = data_reg;
        last_next         = last_reg;
        if (accept)
        begin
            unique case (op)
                ple_pkg::OP_INIT:
                begin
                    count_next = '0;
                end
                ple_pkg::OP_ADD:
                begin
                    if (count_reg != CNT_W'(CAPACITY))
                    begin
                        cell_ctl.mode = ple_pkg::CM_ADD;
                        count_next    = count_reg + CNT_W'(1);
                    end
                end
                ple_pkg::OP_DELETE:
                begin
                    cell_ctl.idx = ple_pkg::IDX_W'(pos_m1);
                    if (pos_ext != '0 && pos_ext <= cnt_ext)
                    begin
                        cell_ctl.mode = ple_pkg::CM_DEL;
                        count_next    = count_reg - CNT_W'(1);
                    end
                end
                ple_pkg::OP_LENGTH:
                begin
                    out_valid_next = 1'b1;
                    kind_next      = ple_pkg::KIND_LEN;
                    data_next      = ple_pkg::DATA_W'(count_reg);
                    last_next      = 1'b1;
                end
                ple_pkg::OP_PRINT:
                begin
                    prn_next = '0;
                    if (count_reg == '0)
                    begin
                        out_valid_next = 1'b1;
                        kind_next      = ple_pkg::KIND_EMPTY;
                        data_next      = '0;
                        last_next      = 1'b1;
                    end
                end
                default:
                begin
                    count_next = count_reg;
                end
            endcase
        end
        else if (state_reg == ple_pkg::ST_PRINT && out_free)
        begin
            cell_ctl.mode  = ple_pkg::CM_ROT;
            prn_next       = prn_reg + CNT_W'(1);
            out_valid_next = 1'b1;
            kind_next      = ple_pkg::KIND_ELEM;
            data_next      = head_data;
            last_next      = prn_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ple_pkg::ST_IDLE;
            count_reg     <= '0;
            prn_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            prn_reg       <= prn_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg <= kind_next;
        data_reg <= data_next;
        last_reg <= last_next;
    end

    assign out_valid = out_valid_reg;
    assign kind      = kind_reg;
    assign data      = data_reg;
    assign last      = last_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/ple_checker.sv -----
// Port-level checker for the positional list engine, bound to the top level.
// Depends on ple_pkg and positional_list_engine_core_macros.svh.
`default_nettype none

`include "positional_list_engine_core_macros.svh"

module ple_checker #(
    parameter int CAPACITY = ple_pkg::CAPACITY_DEF
) (
    input wire                                    clk,
    input wire                                    rst_n,
    input wire                                    in_valid,
    input wire                                    in_ready,
    input wire logic [ple_pkg::OPC_W-1:0]         opcode,
    input wire                                    out_valid,
    input wire                                    out_ready,
    input wire logic [ple_pkg::KIND_W-1:0]        kind,
    input wire logic signed [ple_pkg::DATA_W-1:0] data,
    input wire                                    last
);

    `PLE_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
        out_valid && $stable(kind) && $stable(data) && $stable(last),
        "Stalled output word changed.")

    `PLE_ASSERT_NEXT(a_len_follows, clk, rst_n,
        in_valid && in_ready && opcode == ple_pkg::OP_LENGTH,
        out_valid && kind == ple_pkg::KIND_LEN && last,
        "Length command did not produce its report.")

    `PLE_ASSERT_NOW(a_len_range, clk, rst_n, out_valid && kind == ple_pkg::KIND_LEN,
        data >= 0 && data <= CAPACITY, "Length report out of range.")

    `PLE_ASSERT_NOW(a_empty_word, clk, rst_n, out_valid && kind == ple_pkg::KIND_EMPTY,
        data == 0 && last, "Empty list word malformed.")

    `PLE_ASSERT_NOW(a_walk_blocks, clk, rst_n,
        out_valid && kind == ple_pkg::KIND_ELEM && !last,
        !in_ready, "Input accepted during a print walk.")

endmodule

bind positional_list_engine_core ple_checker #(.CAPACITY(CAPACITY)) u_ple_checker (.*);

`default_nettype wire

// ----- tb/sv/positional_list_engine_core_tb.sv -----
// Self-checking testbench for positional_list_engine_core: a table of directed
// commands, then random traffic, with every output word checked against the table or a list model.
// Depends on ple_pkg and the positional_list_engine_core RTL.
module positional_list_engine_core_tb;

    localparam int LIST_CAP         = ple_pkg::CAPACITY_DEF;
    localparam int TOTAL_COMMANDS   = 130;
    localparam int FILL_AFTER       = 40;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES     = 16;

    localparam logic [ple_pkg::OPC_W-1:0] OP_RSVD_FIRST =
        ple_pkg::OPC_W'(ple_pkg::OP_PRINT + 1);
    localparam logic [ple_pkg::OPC_W-1:0] OP_RSVD_LAST  = '1;

    localparam logic signed [ple_pkg::DATA_W-1:0] VAL_MAX =
        {1'b0, {(ple_pkg::DATA_W-1){1'b1}}};
    localparam logic signed [ple_pkg::DATA_W-1:0] VAL_MIN =
        {1'b1, {(ple_pkg::DATA_W-1){1'b0}}};

    typedef struct packed {
        logic [ple_pkg::KIND_W-1:0]        kind;
        logic signed [ple_pkg::DATA_W-1:0] data;
        logic                              last;
    } word_t;

    typedef struct packed {
        logic [ple_pkg::OPC_W-1:0]         op;
        logic [ple_pkg::POS_W-1:0]         pos;
        logic signed [ple_pkg::DATA_W-1:0] val;
        logic                              typed;
        word_t                             want;
    } row_t;

    localparam word_t NO_WORD     = '{ple_pkg::KIND_ELEM, '0, 1'b0};
    localparam word_t LEN_ZERO    = '{ple_pkg::KIND_LEN, '0, 1'b1};
    localparam word_t EMPTY_PRINT = '{ple_pkg::KIND_EMPTY, '0, 1'b1};

    localparam int DIRECTED_ROWS = 25;

    row_t directed [DIRECTED_ROWS] = '{
        '{ple_pkg::OP_LENGTH, 7'd0,   32'sd0,         1'b1, LEN_ZERO},
        '{ple_pkg::OP_PRINT,  7'd0,   32'sd0,         1'b1, EMPTY_PRINT},
        '{ple_pkg::OP_DELETE, 7'd1,   32'sd0,         1'b0, NO_WORD},
        '{ple_pkg::OP_ADD,    7'd0,   VAL_MAX,        1'b0, NO_WORD},
        '{ple_pkg::OP_ADD,    7'd127, VAL_MIN,        1'b0, NO_WORD},
        '{ple_pkg::OP_ADD,    7'd1,   32'sd0,         1'b0, NO_WORD},
        '{ple_pkg::OP_ADD,    7'd2,   -32'sd1,        1'b0, NO_WORD},
        '{ple_pkg::OP_ADD,    7'd4,   32'sh5555_5555, 1'b0, NO_WORD},
        '{ple_pkg::OP_PRINT,  7'd0,   32'sd0,         1'b0, NO_WORD},
        '{ple_pkg::OP_LENGTH, 7'd0,   32'sd0,         1'b0, NO_WORD},
        '{ple_pkg::OP_DELETE, 7'd0,   32'sd0,         1'b0, NO_WORD},
        '{ple_pkg::OP_DELETE, 7'd127, 32'sd0,         1'b0, NO_WORD},
        '{ple_pkg::OP_DELETE, 7'd6,   32'sd0,         1'b0, NO_WORD},
        '{ple_pkg::OP_DELETE, 7'd5,   32'sd0,         1'b0, NO_WORD},
        '{ple_pkg::OP_DELETE, 7'd1,   32'sd0,         1'b0, NO_WORD},
        '{OP_RSVD_FIRST,      7'd2,   32'sh1234_5678, 1'b0, NO_WORD},
        '{OP_RSVD_LAST,       7'd127, VAL_MIN,        1'b0, NO_WORD},
        '{ple_pkg::OP_PRINT,  7'd0,   32'sd0,         1'b0, NO_WORD},
        '{ple_pkg::OP_INIT,   7'd3,   VAL_MAX,        1'b0, NO_WORD},
        '{ple_pkg::OP_LENGTH, 7'd0,   32'sd0,         1'b1, LEN_ZERO},
        '{ple_pkg::OP_PRINT,  7'd0,   32'sd0,         1'b1, EMPTY_PRINT},
        '{ple_pkg::OP_ADD,    7'd64,  32'shAAAA_AAAA, 1'b0, NO_WORD},
        '{ple_pkg::OP_DELETE, 7'd2,   32'sd0,         1'b0, NO_WORD},
        '{ple_pkg::OP_DELETE, 7'd1,   32'sd0,         1'b0, NO_WORD},
        '{ple_pkg::OP_LENGTH, 7'd0,   32'sd0,         1'b1, LEN_ZERO}
    };

    logic                              clk       = 1'b0;
    logic                              rst_n     = 1'b0;
    logic                              in_valid  = 1'b0;
    logic                              in_ready;
    logic [ple_pkg::OPC_W-1:0]         opcode    = '0;
    logic [ple_pkg::POS_W-1:0]         position  = '0;
    logic signed [ple_pkg::DATA_W-1:0] value     = '0;
    logic                              out_valid;
    logic                              out_ready = 1'b0;
    logic [ple_pkg::KIND_W-1:0]        kind;
    logic signed [ple_pkg::DATA_W-1:0] data;
    logic                              last;

    logic signed [ple_pkg::DATA_W-1:0] stored_values [$];
    word_t                             expected_words [$];
    word_t                             produced [$];
    int unsigned                       fail_count = 0;
    int unsigned                       sent_count = 0;
    bit                                hold_req   = 1'b0;
    bit                                send_burst = 1'b0;
    bit                                recv_burst = 1'b0;

    positional_list_engine_core #(
        .CAPACITY(LIST_CAP)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .opcode(opcode),
        .position(position),
        .value(value),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .kind(kind),
        .data(data),
        .last(last)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Updates the list model and collects the words the command should produce.
    function automatic void apply_command(input logic [ple_pkg::OPC_W-1:0] op,
                                          input logic [ple_pkg::POS_W-1:0] pos,
                                          input logic signed [ple_pkg::DATA_W-1:0] val);
        int p;
        int n;
        int slot;
        p = pos;
        n = stored_values.size();
        produced.delete();
        case (op)
            ple_pkg::OP_INIT:
            begin
                stored_values.delete();
            end
            ple_pkg::OP_ADD:
            begin
                if (n < LIST_CAP)
                begin
                    if (p <= 1)
                        slot = 0;
                    else if (p - 1 > n)
                        slot = n;
                    else
                        slot = p - 1;
                    stored_values.insert(slot, val);
                end
            end
            ple_pkg::OP_DELETE:
            begin
                if (p != 0 && p <= n)
                    stored_values.delete(p - 1);
            end
            ple_pkg::OP_LENGTH:
            begin
                produced.push_back('{ple_pkg::KIND_LEN, ple_pkg::DATA_W'(n), 1'b1});
            end
            ple_pkg::OP_PRINT:
            begin
                if (n == 0)
                    produced.push_back(EMPTY_PRINT);
                else
                    foreach (stored_values[i])
                        produced.push_back('{ple_pkg::KIND_ELEM, stored_values[i],
                                             i == n - 1});
            end
            default:
            begin
                produced.delete();
            end
        endcase
    endfunction

    function automatic logic [ple_pkg::POS_W-1:0] random_position();
        if ($urandom_range(0, 9) < 7)
            return ple_pkg::POS_W'($urandom_range(0, stored_values.size() + 1));
        return ple_pkg::POS_W'($urandom_range(0, (1 << ple_pkg::POS_W) - 1));
    endfunction

    function automatic logic signed [ple_pkg::DATA_W-1:0] random_value();
        case ($urandom_range(0, 19))
            0: return VAL_MAX;
            1: return VAL_MIN;
            2: return '0;
            3: return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [ple_pkg::OPC_W-1:0] random_opcode();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 45)
            return ple_pkg::OP_ADD;
        if (pick < 65)
            return ple_pkg::OP_DELETE;
        if (pick < 75)
            return ple_pkg::OP_LENGTH;
        if (pick < 87)
            return ple_pkg::OP_PRINT;
        if (pick < 92)
            return ple_pkg::OP_INIT;
        return ple_pkg::OPC_W'($urandom_range(OP_RSVD_FIRST, OP_RSVD_LAST));
    endfunction

    task automatic note_failure(input string msg);
        $display("%0t: %s", $time, msg);
        fail_count++;
    endtask

    task automatic send_command(input logic [ple_pkg::OPC_W-1:0] op,
                                input logic [ple_pkg::POS_W-1:0] pos,
                                input logic signed [ple_pkg::DATA_W-1:0] val,
                                input bit typed,
                                input word_t want);
        int unsigned gap;
        if ($urandom_range(0, 15) == 0)
            send_burst = !send_burst;
        gap = send_burst ? 0 : $urandom_range(0, 7);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        opcode   <= op;
        position <= pos;
        value    <= val;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sent_count++;
        apply_command(op, pos, val);
        if (typed)
            expected_words.push_back(want);
        else
            foreach (produced[i])
                expected_words.push_back(produced[i]);
    endtask

    task automatic check_word(input word_t got);
        word_t want;
        if (expected_words.size() == 0)
        begin
            note_failure($sformatf("unexpected word, expected none, got kind %0d data %0d last %0d",
                                   got.kind, got.data, got.last));
            return;
        end
        want = expected_words.pop_front();
        if (got.kind !== want.kind)
            note_failure($sformatf("kind mismatch, expected %0d, got %0d", want.kind, got.kind));
        if (got.data !== want.data)
            note_failure($sformatf("data mismatch, expected %0d, got %0d", want.data, got.data));
        if (got.last !== want.last)
            note_failure($sformatf("last mismatch, expected %0d, got %0d", want.last, got.last));
    endtask

    initial
    begin : stimulus
        bit filled;
        filled = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (directed[i])
            send_command(directed[i].op, directed[i].pos, directed[i].val,
                         directed[i].typed, directed[i].want);
        while (sent_count < TOTAL_COMMANDS)
        begin
            if (!filled && sent_count >= FILL_AFTER)
            begin
                filled = 1'b1;
                // The receiver holds off while the list is filled, so that a length word
                // backs up in the output register and the input stalls behind it.
                hold_req = 1'b1;
                send_command(ple_pkg::OP_LENGTH, '0, '0, 1'b0, NO_WORD);
                send_command(ple_pkg::OP_LENGTH, '0, '0, 1'b0, NO_WORD);
                while (stored_values.size() < LIST_CAP)
                    send_command(ple_pkg::OP_ADD, random_position(), random_value(), 1'b0,
                                 NO_WORD);
                send_command(ple_pkg::OP_ADD, '0, random_value(), 1'b0, NO_WORD);
                send_command(ple_pkg::OP_ADD, '1, random_value(), 1'b0, NO_WORD);
                send_command(ple_pkg::OP_ADD, random_position(), random_value(), 1'b0,
                             NO_WORD);
                send_command(ple_pkg::OP_PRINT, '0, '0, 1'b0, NO_WORD);
                send_command(ple_pkg::OP_LENGTH, '0, '0, 1'b0, NO_WORD);
                send_command(ple_pkg::OP_DELETE, ple_pkg::POS_W'(LIST_CAP + 1), '0, 1'b0,
                             NO_WORD);
                send_command(ple_pkg::OP_DELETE, ple_pkg::POS_W'(LIST_CAP), '0, 1'b0,
                             NO_WORD);
                send_command(ple_pkg::OP_ADD, '0, random_value(), 1'b0, NO_WORD);
                send_command(ple_pkg::OP_PRINT, '0, '0, 1'b0, NO_WORD);
            end
            else
            begin
                send_command(random_opcode(), random_position(), random_value(), 1'b0,
                             NO_WORD);
            end
        end
        in_valid <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin : drain
        int unsigned gap;
        word_t       got;
        do
            @(posedge clk);
        while (!rst_n);
        forever
        begin
            if ($urandom_range(0, 15) == 0)
                recv_burst = !recv_burst;
            gap = recv_burst ? 0 : $urandom_range(0, 7);
            if (hold_req)
            begin
                hold_req = 1'b0;
                gap = LONG_HOLD_CYCLES;
            end
            if (gap != 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            got = '{kind, data, last};
            check_word(got);
        end
    end

    initial
    begin : watchdog
        #4000000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/ple_pkg.sv
hw/rtl/ple_cell.sv
hw/rtl/ple_ctrl.sv
hw/rtl/positional_list_engine_core.sv
hw/rtl/ple_checker.sv
tb/sv/positional_list_engine_core_tb.sv
